[hdl/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int DEPTH          = 16;
    localparam int TAG_WIDTH      = 16;
    localparam int PRIORITY_WIDTH = 4;
    localparam int ADDR_WIDTH     = $clog2(DEPTH);
    localparam int COUNT_WIDTH    = $clog2(DEPTH + 1);

    localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = COUNT_WIDTH'(DEPTH);

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                      action;
        logic [TAG_WIDTH-1:0]      tag;
        logic [PRIORITY_WIDTH-1:0] priority_req;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                status;
        logic [TAG_WIDTH-1:0]      out_tag;
        logic [PRIORITY_WIDTH-1:0] out_priority;
    } t_out_item;

    typedef struct packed {
        logic [TAG_WIDTH-1:0]      tag;
        logic [PRIORITY_WIDTH-1:0] pri;
    } t_entry;

    typedef struct packed {
        logic                  en;
        logic [ADDR_WIDTH-1:0] addr;
        t_entry                data;
    } t_wr_req;

endpackage

[hdl/spq_store.sv]
// Entry memory: one write port, one registered read port.
module spq_store (
    input  logic                           i_clk,
    input  spq_pkg::t_wr_req               i_wr,
    input  logic [spq_pkg::ADDR_WIDTH-1:0] i_rd_addr,
    output spq_pkg::t_entry                o_rd_data
);

    spq_pkg::t_entry r_mem [spq_pkg::DEPTH];
    spq_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/spq_seq.sv]
// Sequencer: insertion walk on enqueue, shift walk on dequeue, one entry per cycle.
module spq_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  spq_pkg::t_in_item              i_in,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output spq_pkg::t_out_item             o_res,
    output spq_pkg::t_wr_req               o_wr,
    output logic [spq_pkg::ADDR_WIDTH-1:0] o_rd_addr,
    input  spq_pkg::t_entry                i_rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ENQ,
        S_DEQ,
        S_DONE
    } t_state;

    t_state                              r_state, n_state;
    logic [spq_pkg::COUNT_WIDTH-1:0]     r_count, n_count;
    logic [spq_pkg::COUNT_WIDTH-1:0]     r_idx, n_idx;
    logic [spq_pkg::TAG_WIDTH-1:0]       r_tag, n_tag;
    logic [spq_pkg::PRIORITY_WIDTH-1:0]  r_pri, n_pri;
    spq_pkg::t_out_item                  r_res, n_res;

    logic                                accept;
    logic [spq_pkg::COUNT_WIDTH-1:0]     count_m1;
    logic [spq_pkg::COUNT_WIDTH-1:0]     idx_m1;
    logic [spq_pkg::COUNT_WIDTH-1:0]     idx_m2;
    logic [spq_pkg::COUNT_WIDTH-1:0]     idx_p1;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    assign count_m1 = r_count - 1'b1;
    assign idx_m1   = r_idx - 1'b1;
    assign idx_m2   = r_idx - 2'd2;
    assign idx_p1   = r_idx + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_tag     = r_tag;
        n_pri     = r_pri;
        n_res     = r_res;
        o_wr      = '0;
        o_rd_addr = '0;

        case (r_state)
            S_IDLE: begin
                o_rd_addr = (i_in.action == spq_pkg::ACT_DEQ) ? '0
                          : count_m1[spq_pkg::ADDR_WIDTH-1:0];
                if (accept) begin
                    n_tag = i_in.tag;
                    n_pri = i_in.priority_req;
                    n_res = '0;
                    if (i_in.action == spq_pkg::ACT_ENQ) begin
                        if (r_count == spq_pkg::COUNT_FULL) begin
                            n_res.status = spq_pkg::STATUS_FULL;
                            n_state      = S_DONE;
                        end else begin
                            n_idx   = r_count;
                            n_state = S_ENQ;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res.status = spq_pkg::STATUS_EMPTY;
                            n_state      = S_DONE;
                        end else begin
                            n_idx   = '0;
                            n_state = S_DEQ;
                        end
                    end
                end
            end
            S_ENQ: begin
                o_rd_addr   = idx_m2[spq_pkg::ADDR_WIDTH-1:0];
                o_wr.en     = 1'b1;
                o_wr.addr   = r_idx[spq_pkg::ADDR_WIDTH-1:0];
                if (r_idx == '0 || i_rd_data.pri >= r_pri) begin
                    o_wr.data.tag = r_tag;
                    o_wr.data.pri = r_pri;
                    n_count       = r_count + 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_wr.data = i_rd_data;
                    n_idx     = idx_m1;
                end
            end
            S_DEQ: begin
                o_rd_addr = idx_p1[spq_pkg::ADDR_WIDTH-1:0];
                if (r_idx == '0) begin
                    n_res.out_tag      = i_rd_data.tag;
                    n_res.out_priority = i_rd_data.pri;
                end else begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = idx_m1[spq_pkg::ADDR_WIDTH-1:0];
                    o_wr.data = i_rd_data;
                end
                if (r_idx == count_m1) begin
                    n_count = count_m1;
                    n_state = S_DONE;
                end else begin
                    n_idx = idx_p1;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx <= n_idx;
        r_tag <= n_tag;
        r_pri <= n_pri;
        r_res <= n_res;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spq_pkg::COUNT_FULL)
        else $error("entry count above depth");

    a_enq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ENQ |-> (r_idx <= r_count && r_count != spq_pkg::COUNT_FULL))
        else $error("insertion walk out of range");

    a_deq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DEQ |-> r_idx < r_count)
        else $error("shift walk out of range");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res.status == spq_pkg::STATUS_FULL)
        |-> r_count == spq_pkg::COUNT_FULL)
        else $error("full status with room left");

    a_deq_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEQ && n_state == S_DONE) |=> r_count == $past(r_count) - 1'b1)
        else $error("dequeue did not remove one entry");
`endif

endmodule

[hdl/sorted_priority_queue_core.sv]
// Sorted-array priority queue, top level with result register.
// The input is ready again in the cycle after the previous result enters the output
// register, so each item waits for the one-entry-per-cycle walk over the entry memory
// (one write port, one registered read port). Reset (i_rst_n low, synchronous) empties the queue.
module sorted_priority_queue_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  spq_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output spq_pkg::t_out_item o_out
);

    spq_pkg::t_wr_req               wr;
    logic [spq_pkg::ADDR_WIDTH-1:0] rd_addr;
    spq_pkg::t_entry                rd_data;
    logic                           res_valid;
    logic                           res_ready;
    spq_pkg::t_out_item             res;

    logic                           r_out_valid;
    spq_pkg::t_out_item             r_out;

    spq_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    spq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_wr        (wr),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[bench/sorted_priority_queue_core_tb.sv]
// Self-checking testbench for the sorted priority queue core.
`timescale 1ns / 1ps

module sorted_priority_queue_core_tb;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_LEN    = 300;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               out_ready = 1'b0;
    spq_pkg::t_in_item  in_item = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    spq_pkg::t_out_item o_out;

    // model of the stored entries
    logic [spq_pkg::TAG_WIDTH-1:0]      queued_tag [spq_pkg::DEPTH];
    logic [spq_pkg::PRIORITY_WIDTH-1:0] queued_pri [spq_pkg::DEPTH];
    int                                 queued_count = 0;

    spq_pkg::t_out_item pending_results[$];
    int                 error_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_cycles = 0;
    int                 quiet_cycles = 0;

    sorted_priority_queue_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    always #10 i_clk = ~i_clk;

    function automatic spq_pkg::t_out_item apply_queue_op(spq_pkg::t_in_item req);
        spq_pkg::t_out_item res;
        int                 pos;
        int                 i;
        res = '0;
        res.status = spq_pkg::STATUS_OK;
        if (req.action == spq_pkg::ACT_ENQ) begin
            if (queued_count >= spq_pkg::DEPTH) begin
                res.status = spq_pkg::STATUS_FULL;
            end else begin
                pos = 0;
                while (pos < queued_count && queued_pri[pos] >= req.priority_req)
                    pos++;
                for (i = queued_count; i > pos; i--) begin
                    queued_tag[i] = queued_tag[i-1];
                    queued_pri[i] = queued_pri[i-1];
                end
                queued_tag[pos] = req.tag;
                queued_pri[pos] = req.priority_req;
                queued_count++;
            end
        end else begin
            if (queued_count == 0) begin
                res.status = spq_pkg::STATUS_EMPTY;
            end else begin
                res.out_tag      = queued_tag[0];
                res.out_priority = queued_pri[0];
                for (i = 1; i < queued_count; i++) begin
                    queued_tag[i-1] = queued_tag[i];
                    queued_pri[i-1] = queued_pri[i];
                end
                queued_count--;
            end
        end
        return res;
    endfunction

    function automatic spq_pkg::t_in_item make_request(int enq_pct, int pri_max);
        spq_pkg::t_in_item req;
        req.action       = ($urandom_range(99) < enq_pct) ? spq_pkg::ACT_ENQ
                                                          : spq_pkg::ACT_DEQ;
        req.tag          = spq_pkg::TAG_WIDTH'($urandom);
        req.priority_req = spq_pkg::PRIORITY_WIDTH'($urandom_range(pri_max, 0));
        return req;
    endfunction

    task automatic send_item(input spq_pkg::t_in_item req);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(apply_queue_op(req));
    endtask

    task automatic send_fields(input logic act,
                               input logic [spq_pkg::TAG_WIDTH-1:0] tag,
                               input logic [spq_pkg::PRIORITY_WIDTH-1:0] pri);
        spq_pkg::t_in_item req;
        req.action       = act;
        req.tag          = tag;
        req.priority_req = pri;
        send_item(req);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // receiver: random stalls, plus one long hold-off in the backpressure test
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            out_ready   <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        spq_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item status %0d tag %h pri %0d", $realtime,
                         o_out.status, o_out.out_tag, o_out.out_priority);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out.status !== want.status || o_out.out_tag !== want.out_tag ||
                    o_out.out_priority !== want.out_priority) begin
                    $display({"%0t: mismatch expected status %0d tag %h pri %0d, ",
                              "got status %0d tag %h pri %0d"},
                             $realtime, want.status, want.out_tag, want.out_priority,
                             o_out.status, o_out.out_tag, o_out.out_priority);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic test_directed();
        int i;
        send_fields(spq_pkg::ACT_DEQ, 16'hffff, 4'hf);
        send_fields(spq_pkg::ACT_ENQ, 16'h0000, 4'h0);
        send_fields(spq_pkg::ACT_ENQ, 16'hffff, 4'hf);
        send_fields(spq_pkg::ACT_ENQ, 16'h1234, 4'hf);
        send_fields(spq_pkg::ACT_ENQ, 16'h5678, 4'h0);
        send_fields(spq_pkg::ACT_ENQ, 16'haaaa, 4'h7);
        send_fields(spq_pkg::ACT_ENQ, 16'h5555, 4'h7);
        for (i = 0; i < 10; i++)
            send_fields(spq_pkg::ACT_ENQ, spq_pkg::TAG_WIDTH'(16'h0100 + i),
                        spq_pkg::PRIORITY_WIDTH'(i % 4 * 5));
        send_fields(spq_pkg::ACT_ENQ, 16'hbeef, 4'h9);
        for (i = 0; i < 6; i++)
            send_fields(spq_pkg::ACT_DEQ, 16'hffff, 4'hf);
        wait_drained();
    endtask

    task automatic test_random_phase(input int n_items, input int s_pct, input int r_pct);
        int i;
        int enq_pct;
        int pri_max;
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        enq_pct = 50;
        pri_max = 15;
        for (i = 0; i < n_items; i++) begin
            if (i % 20 == 0) begin
                case ($urandom_range(2))
                    0: enq_pct = 20;
                    1: enq_pct = 50;
                    default: enq_pct = 85;
                endcase
                pri_max = ($urandom_range(1)) ? 15 : $urandom_range(3);
            end
            send_item(make_request(enq_pct, pri_max));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        int i;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = HOLD_LEN;
        for (i = 0; i < 12; i++)
            send_item(make_request(70, 15));
        wait_drained();
        for (i = 0; i < 8; i++)
            send_item(make_request(50, 15));
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_phase(300, 0, 0);
        test_random_phase(300, 52, 0);
        test_random_phase(300, 0, 52);
        test_random_phase(300, 33, 33);
        test_backpressure();

        repeat (spq_pkg::DEPTH + 8) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/spq_pkg.sv
hdl/spq_store.sv
hdl/spq_seq.sv
hdl/sorted_priority_queue_core.sv
bench/sorted_priority_queue_core_tb.sv
